// ===== sv/vcf_pkg.sv =====
`default_nettype none
package vcf_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CRC_POLY   = 8'h8C;
  localparam logic [7:0] SYNC_BYTE  = 8'h5A;
  localparam logic [7:0] LEN_BYTE   = 8'h0C;
  localparam logic [7:0] ONE_BYTE   = 8'h01;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  localparam logic MODE_SERIAL = 1'b0;
  localparam logic MODE_CAN    = 1'b1;
  localparam logic MODE_RESET  = MODE_CAN;

  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] SER_CRC_IDX  = 4'd11;
  localparam logic [IDX_W-1:0] SER_LAST_IDX = 4'd13;
  localparam logic [IDX_W-1:0] CAN_CRC_IDX  = 4'd7;
  localparam logic [IDX_W-1:0] CAN_LAST_IDX = 4'd7;

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] angular_speed;
  } cmd_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frame_t;

  // one classified request as held in the queue
  typedef struct packed {
    cmd_t       cmd;
    logic       link_mode;
    logic [7:0] cnt;
  } job_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] acc_in, input logic [7:0] d);
    logic [7:0] acc;
    logic [7:0] v;
    logic       mix;
    acc = acc_in;
    v   = d;
    for (int b = 0; b < 8; b++) begin
      mix = acc[0] ^ v[0];
      acc = acc >> 1;
      if (mix) acc = acc ^ CRC_POLY;
      v = v >> 1;
    end
    return acc;
  endfunction

  function automatic logic [7:0] frame_byte_at(input job_t j, input logic [IDX_W-1:0] idx,
                                               input logic [7:0] crc);
    logic [7:0] r;
    r = ZERO_BYTE;
    if (j.link_mode == MODE_SERIAL) begin
      unique case (idx)
        4'd0:        r = SYNC_BYTE;
        4'd1:        r = LEN_BYTE;
        4'd2:        r = ONE_BYTE;
        4'd3:        r = ONE_BYTE;
        4'd4:        r = j.cmd.linear_speed[15:8];
        4'd5:        r = j.cmd.linear_speed[7:0];
        4'd8:        r = j.cmd.angular_speed[15:8];
        4'd9:        r = j.cmd.angular_speed[7:0];
        SER_CRC_IDX: r = crc;
        4'd12:       r = CR_BYTE;
        4'd13:       r = LF_BYTE;
        default:     r = ZERO_BYTE;
      endcase
    end else begin
      unique case (idx)
        4'd0:        r = j.cmd.linear_speed[15:8];
        4'd1:        r = j.cmd.linear_speed[7:0];
        4'd4:        r = j.cmd.angular_speed[15:8];
        4'd5:        r = j.cmd.angular_speed[7:0];
        4'd6:        r = j.cnt;
        CAN_CRC_IDX: r = crc;
        default:     r = ZERO_BYTE;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/vcf_front.sv =====
`default_nettype none
module vcf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire vcf_pkg::cmd_t in_cmd,
  output logic               push,
  output vcf_pkg::job_t      push_job,
  input  wire logic          q_full
);

  logic       link_mode_r;
  logic [7:0] cnt_r, cnt_nxt;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign push_job.cmd       = in_cmd;
  assign push_job.link_mode = link_mode_r;
  assign push_job.cnt       = cnt_r;

  // counter only moves on CAN frames, wraps naturally
  assign cnt_nxt = (push && link_mode_r == vcf_pkg::MODE_CAN) ? cnt_r + 8'd1 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_mode_r <= vcf_pkg::MODE_RESET;
      cnt_r       <= 8'd0;
    end else begin
      if (cfg_we) link_mode_r <= cfg_wdata;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/vcf_queue.sv =====
`default_nettype none
module vcf_queue #(
  parameter int DEPTH = vcf_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire vcf_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output vcf_pkg::job_t      head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vcf_pkg::job_t         mem [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]      count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/vcf_back.sv =====
`default_nettype none
module vcf_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire vcf_pkg::job_t head_job,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output vcf_pkg::frame_t    out_frame
);

  vcf_pkg::job_t                 cur_r;
  logic                          busy_r;
  logic [vcf_pkg::IDX_W-1:0]     idx_r;
  logic [7:0]                    crc_r;
  logic                          out_valid_r;
  vcf_pkg::frame_t               out_frame_r;

  logic                          adv, last_now;
  logic [7:0]                    byte_now;
  logic [vcf_pkg::IDX_W-1:0]     last_idx;

  assign last_idx = (cur_r.link_mode == vcf_pkg::MODE_SERIAL) ? vcf_pkg::SER_LAST_IDX
                                                              : vcf_pkg::CAN_LAST_IDX;
  assign last_now = (idx_r == last_idx);
  assign byte_now = vcf_pkg::frame_byte_at(cur_r, idx_r, crc_r);
  assign adv      = busy_r && (!out_valid_r || !out_stall);
  // pick up the next request on the same cycle the final byte goes out
  assign pop      = head_valid && (!busy_r || (adv && last_now));

  assign out_valid = out_valid_r;
  assign out_frame = out_frame_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_job;
      idx_r <= '0;
      crc_r <= 8'd0;
    end else if (adv) begin
      idx_r <= idx_r + 1'b1;
      crc_r <= vcf_pkg::crc8_byte(crc_r, byte_now);
    end
    if (adv) begin
      out_frame_r.frame_byte <= byte_now;
      out_frame_r.frame_last <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop)                  busy_r <= 1'b1;
      else if (adv && last_now) busy_r <= 1'b0;
      if (adv)             out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/velocity_command_framer_top.sv =====
`default_nettype none
// Velocity command framer: each accepted request (linear and angular speed) becomes a byte
// frame sent one byte per cycle on the out_ channel unless out_stall holds it, frame_last
// marking the final byte. With link_mode 0 a frame is 14 bytes (sync header, speeds,
// CRC-8/MAXIM, CR LF); with link_mode 1 it is the 8-byte CAN payload with rolling counter
// and CRC. The back-end serializer emits one byte per cycle through its output register
// while out_stall is low; the front end and a DEPTH-entry request queue take new requests
// while a frame is still going out. Write cfg_wdata only with no frame pending.
module velocity_command_framer_top #(
  parameter int QUEUE_DEPTH = vcf_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire vcf_pkg::cmd_t in_cmd,
  output logic               out_valid,
  input  wire logic          out_stall,
  output vcf_pkg::frame_t    out_frame
);

  logic          push, q_full, pop, head_valid;
  vcf_pkg::job_t push_job, head_job;

  vcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  vcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  vcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_frame  (out_frame)
  );

endmodule
`default_nettype wire

// ===== sv/vcf_checker.sv =====
`default_nettype none
module vcf_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            cfg_we,
  input wire logic            cfg_wdata,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire vcf_pkg::frame_t out_frame
);

  logic mode_r;
  logic first_r;
  logic out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= vcf_pkg::MODE_RESET;
      first_r <= 1'b1;
    end else begin
      if (cfg_we)   mode_r  <= cfg_wdata;
      if (out_take) first_r <= out_frame.frame_last;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame))
    else $error("stalled result changed");

  a_serial_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && first_r && mode_r == vcf_pkg::MODE_SERIAL |->
      out_frame.frame_byte == vcf_pkg::SYNC_BYTE)
    else $error("serial frame does not open with sync byte");

  a_serial_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && out_frame.frame_last && mode_r == vcf_pkg::MODE_SERIAL |->
      out_frame.frame_byte == vcf_pkg::LF_BYTE)
    else $error("serial frame does not end with LF");

endmodule

bind velocity_command_framer_top vcf_checker u_vcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_frame (out_frame)
);
`default_nettype wire
